// ===== hdl/assert_macros.svh =====
// Assertion macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

// ===== hdl/fmt_pkg.sv =====
// Types and constants for the truncating single-precision multiplier.
package fmt_pkg;
   localparam int unsigned BIAS = 127;
   localparam int unsigned FRAC_BITS = 23;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_OVER  = 2'd2,
      ST_UNDER = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] product;
      logic [1:0]  status;
   } rsp_type;

   // Operand fields registered after the significand multiply.
   typedef struct packed {
      logic        zero;
      logic        sign;
      logic [8:0]  exp_sum;
      logic [47:0] mant;
   } stage_type;
endpackage

// ===== hdl/fmt_mul_stage.sv =====
// Input register stage: zero detect, exponent sum and significand multiply.
module fmt_mul_stage import fmt_pkg::*; (
   input  logic      clock,
   input  logic      advance,
   input  req_type   req,
   output stage_type stage
);
   stage_type stage_ff, stage_in;
   logic [23:0] ma, mb;

   always_comb begin
      ma = {1'b1, req.operand_a[22:0]};
      mb = {1'b1, req.operand_b[22:0]};
      stage_in.zero = (req.operand_a[30:0] == 31'd0) || (req.operand_b[30:0] == 31'd0);
      stage_in.sign = req.operand_a[31] ^ req.operand_b[31];
      stage_in.exp_sum = {1'b0, req.operand_a[30:23]} + {1'b0, req.operand_b[30:23]};
      stage_in.mant = ma * mb;
   end

   always_ff @(posedge clock) begin
      if (advance) stage_ff <= stage_in;
   end

   assign stage = stage_ff;
endmodule

// ===== hdl/fmt_pack_stage.sv =====
// Result stage: normalize, range check and pack the product word.
module fmt_pack_stage import fmt_pkg::*; (
   input  logic      clock,
   input  logic      advance,
   input  stage_type stage,
   output rsp_type   rsp
);
   rsp_type rsp_ff, rsp_in;
   logic signed [10:0] exp_adj;
   logic [22:0] frac;

   always_comb begin
      exp_adj = $signed({2'b00, stage.exp_sum}) - 11'sd127 + $signed({10'd0, stage.mant[47]});
      frac = stage.mant[47] ? stage.mant[46:24] : stage.mant[45:23];
      rsp_in.product = '0;
      if (stage.zero) begin
         rsp_in.status = ST_ZERO;
      end else if (exp_adj > 11'sd255) begin
         rsp_in.status = ST_OVER;
      end else if (exp_adj < 11'sd0) begin
         rsp_in.status = ST_UNDER;
      end else begin
         rsp_in.status = ST_OK;
         rsp_in.product = {stage.sign, exp_adj[7:0], frac};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;
endmodule

// ===== hdl/float32_multiplier_truncating_top.sv =====
// Top level of the truncating single-precision multiplier.
// Usage:
//   The req channel carries an operand pair (req_payload) qualified by req_valid;
//   a pair transfers when req_valid is high and req_stall is low.
//   The rsp channel returns product and status on rsp_payload with rsp_valid;
//   a result transfers when rsp_valid is high and rsp_stall is low.
//   A transferred pair is registered after the significand multiply and again
//   after normalize and pack; rsp_valid rises once it is in the result register.
//   Throughput is one pair per cycle while rsp is not stalled; the two-stage
//   pipeline sets it.
//   A stall on rsp holds the result register while empty stages behind it
//   still fill; req_stall rises only while the result register holds an
//   untaken result and every stage is full.
//   Reset clears the stage valid bits; no results are pending afterward.
//   Status codes: ok, zero operand (+0), exponent overflow, underflow (zero word).
//   Significands are truncated, never rounded; the exponent field
//   values zero and all-ones are treated as ordinary numbers.
module float32_multiplier_truncating_top import fmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);
   logic v1_ff, v1_in, v2_ff, v2_in;
   logic adv2, adv1;
   stage_type stage;

   // A stage advances when downstream can take it.
   assign adv2 = !v2_ff || !rsp_stall;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   fmt_mul_stage u_mul (
      .clock(clock), .advance(adv1), .req(req_payload), .stage(stage)
   );

   fmt_pack_stage u_pack (
      .clock(clock), .advance(adv2), .stage(stage), .rsp(rsp_payload)
   );

   assign rsp_valid = v2_ff;
endmodule

// ===== hdl/fmt_checker.sv =====
// Port-level checker for the multiplier, bound to the top level.
`include "assert_macros.svh"
module fmt_checker import fmt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `CHK_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_payload.status != ST_OK, rsp_payload.product == 32'd0)
   `CHK_IMPLY(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `CHK_IMPLY(a_no_stall_free, clock, reset, !rsp_valid, !req_stall)
endmodule

bind float32_multiplier_truncating_top fmt_checker u_fmt_checker (.*);

// ===== tb/sv/tb_float32_multiplier_truncating_top.sv =====
// Testbench for the truncating single-precision multiplier: directed and random operand pairs.
`timescale 1ns / 100ps

module tb_float32_multiplier_truncating_top;
   import fmt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   rsp_type expected_products[$];
   int      fail_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_off_cycles = 0;

   always #5 clock = ~clock;

   float32_multiplier_truncating_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   function automatic rsp_type multiply_truncated(logic [31:0] a, logic [31:0] b);
      rsp_type        r;
      logic [47:0]    mant;
      logic signed [11:0] exp_adj;
      logic [22:0]    frac;
      r = '0;
      if ((a[30:0] == '0) || (b[30:0] == '0)) begin
         r.status = ST_ZERO;
         return r;
      end
      mant = {1'b1, a[22:0]} * {1'b1, b[22:0]};
      exp_adj = $signed({4'b0, a[30:23]}) + $signed({4'b0, b[30:23]}) - 12'sd127
         + $signed({11'b0, mant[47]});
      if (exp_adj > 12'sd255) begin
         r.status = ST_OVER;
      end else if (exp_adj < 12'sd0) begin
         r.status = ST_UNDER;
      end else begin
         frac = mant[47] ? mant[46:24] : mant[45:23];
         r.product = {a[31] ^ b[31], exp_adj[7:0], frac};
         r.status = ST_OK;
      end
      return r;
   endfunction

   task automatic send_pair(logic [31:0] a, logic [31:0] b);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{operand_a: a, operand_b: b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_products.push_back(multiply_truncated(a, b));
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] make_float(logic s, logic [7:0] e, logic [22:0] f);
      return {s, e, f};
   endfunction

   // Exponent fields are biased toward the range where products stay normal.
   function automatic logic [31:0] random_operand();
      logic [7:0] e;
      case ($urandom_range(9, 0))
         0: return $urandom();
         1: return make_float(1'($urandom_range(1, 0)), 8'd0, 23'd0);
         2: e = 8'($urandom_range(255, 200));
         3: e = 8'($urandom_range(60, 0));
         default: e = 8'($urandom_range(190, 64));
      endcase
      return make_float(1'($urandom_range(1, 0)), e, 23'($urandom()));
   endfunction

   task automatic test_directed();
      send_pair(32'h3F80_0000, 32'h3F80_0000);
      send_pair(32'h0000_0000, 32'hFFFF_FFFF);
      send_pair(32'hBF80_0000, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h0000_0001, 32'h3F80_0000);
      send_pair(32'h0080_0000, 32'h3F80_0000);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'h3F80_0000);
      send_pair(32'h7F80_0000, 32'h4000_0000);
      send_pair(32'h7F80_0000, 32'h3FFF_FFFF);
      send_pair(32'h3F80_0000, 32'h007F_FFFF);
      send_pair(32'h0000_0001, 32'h0000_0001);
      send_pair(32'h3F00_0000, 32'h0080_0000);
      send_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF);
      send_pair(32'hC0FF_FFFF, 32'h40AA_AAAA);
      send_pair(32'h5555_5555, 32'hAAAA_AAAA);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair(32'h43FF_0000, 32'h3B80_0000);
      go_idle();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_pair(random_operand(), random_operand());
      go_idle();
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 60;
      for (int i = 0; i < 40; i++) send_pair(random_operand(), random_operand());
      go_idle();
   endtask

   task automatic wait_drained();
      while (expected_products.size() > 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver stall: a long hold-off when requested, otherwise random.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_products.size() == 0) begin
            $error("unexpected transfer: product %h status %0d",
               rsp_payload.product, rsp_payload.status);
            fail_count++;
         end else begin
            want = expected_products.pop_front();
            if (rsp_payload.product !== want.product) begin
               $error("product expected %h actual %h", want.product, rsp_payload.product);
               fail_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_payload.status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      send_idle_pct = 32;
      recv_idle_pct = 51;
      test_random(500);
      test_backpressure();
      send_idle_pct = 51;
      recv_idle_pct = 32;
      test_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(500);
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_products.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
